[rtl/crbcd_pkg.sv]
// ----------------------------------------------------------------------------
// crbcd_pkg
// shared types and constants of the clock replacement block cache directory
// ----------------------------------------------------------------------------
package crbcd_pkg;

	localparam int KEY_W = 32;
	localparam int CNT_W = 32;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_STORE  = 2'd1;
	localparam logic [1:0] ACT_REPORT = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [2:0] OUT_MISS     = 3'd0;
	localparam logic [2:0] OUT_HIT      = 3'd1;
	localparam logic [2:0] OUT_FREE     = 3'd2;
	localparam logic [2:0] OUT_EVICT    = 3'd3;
	localparam logic [2:0] OUT_RESIDENT = 3'd4;
	localparam logic [2:0] OUT_VERIFIED = 3'd5;
	localparam logic [2:0] OUT_MISMATCH = 3'd6;

	localparam logic [0:0] REG_SLOT_COUNT  = 1'd0;
	localparam logic [0:0] REG_VERIFY_MODE = 1'd1;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] REPORT_EVERY = 32'd1024;
	localparam logic [31:0] REPORT_LATE  = 32'd8192;
	localparam logic [31:0] REPORT_LIMIT = 32'd8192;

	typedef struct packed {
		logic [1:0]       action;
		logic [KEY_W-1:0] key_archive;
		logic [KEY_W-1:0] key_handle;
		logic [KEY_W-1:0] key_offset;
		logic [KEY_W-1:0] key_packed_size;
		logic [KEY_W-1:0] key_unpacked_size;
		logic             data_match;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       outcome;
		logic [9:0]       slot_index;
		logic             is_poisoned;
		logic             report_due;
		logic [CNT_W-1:0] request_count;
		logic [CNT_W-1:0] hit_count;
		logic [CNT_W-1:0] store_count;
		logic [CNT_W-1:0] eviction_count;
		logic [CNT_W-1:0] verified_count;
		logic [CNT_W-1:0] mismatch_count;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0] tag;
		logic [KEY_W-1:0] archive;
		logic [KEY_W-1:0] handle;
		logic [KEY_W-1:0] offset;
		logic [KEY_W-1:0] packed_size;
		logic [KEY_W-1:0] unpacked_size;
	} entry_t;

	function automatic logic [31:0] fnv_byte(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * FNV_PRIME;
	endfunction

endpackage

[rtl/crbcd_hash.sv]
// ----------------------------------------------------------------------------
// crbcd_hash
// fnv-1a tag over the 20 key bytes, one byte per cycle
// ----------------------------------------------------------------------------
module crbcd_hash (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [5*crbcd_pkg::KEY_W-1:0] key,
	output logic                        done,
	output logic [31:0]                 tag
);
	import crbcd_pkg::*;

	logic [4:0]  idx_q;
	logic        busy_q;
	logic [31:0] h_q;
	logic [7:0]  byte_sel;

	// key packed with archive in the top word; byte order is lsb first per word
	always_comb begin
		logic [2:0] w;
		logic [1:0] b;
		w = idx_q[4:2];
		b = idx_q[1:0];
		byte_sel = key[(3'd4 - w) * 32 + b * 8 +: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (idx_q == 5'd19) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				idx_q <= idx_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			h_q <= FNV_BASIS;
		else if (busy_q)
			h_q <= fnv_byte(h_q, byte_sel);
	end

	assign tag = h_q;

endmodule

[rtl/clock_replacement_block_cache_directory.sv]
// ----------------------------------------------------------------------------
// clock_replacement_block_cache_directory
// fully associative block cache directory with clock replacement
// ----------------------------------------------------------------------------
// items enter on in_valid/in_ready and leave on out_valid/out_ready, one
// result item per input item. config writes use cfg_valid/cfg_ready with
// cfg_index 0 for slot_count and 1 for verify_mode, taken only while idle
// and no input item is offered.
// an item is handled one at a time: the tag is hashed, then the slot
// memory is scanned slot by slot, then for a store miss a clock sweep of
// at most 2n+3 steps runs over the same memory read address, for n active
// slots. a report or an ignored item goes straight to the output register.
// the key memory and flag memory each have one read and one write port and
// share one read address, so these steps run one after another.
// reset clears the used and referenced flags with a pass over MAX_SLOTS
// entries, one per cycle, during which no item is accepted. counters, hand
// and poison flag clear at once. a result waits in an output register while
// the receiver stalls; the next item is accepted only once it is taken.
// ----------------------------------------------------------------------------
module clock_replacement_block_cache_directory #(
	parameter int MAX_SLOTS  = 1024,
	parameter int SLOT_BYTES = 262144
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  crbcd_pkg::in_item_t    in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output crbcd_pkg::out_item_t   out_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [10:0]            cfg_data
);
	import crbcd_pkg::*;

	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int NW = AW + 1;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_HASH  = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_SCHK  = 4'd4;
	localparam logic [3:0] ST_HIT   = 4'd5;
	localparam logic [3:0] ST_VRD   = 4'd6;
	localparam logic [3:0] ST_VCHK  = 4'd7;
	localparam logic [3:0] ST_WR    = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0]    st_q;
	logic [10:0]   slot_count_q;
	logic          verify_q;
	logic          poison_q;
	logic [AW-1:0] hand_q;
	logic [CNT_W-1:0] c_req_q, c_hit_q, c_store_q, c_evict_q, c_ver_q, c_mis_q;
	in_item_t      it_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] scan_q;
	logic [AW-1:0] addr_s1;
	logic [AW-1:0] slot_q;
	logic [NW+1:0] steps_q;
	logic          reused_q;
	logic [AW-1:0] clr_q;
	logic          hash_start;
	logic          hash_done;
	logic [31:0]   tag;
	logic [2:0]    outcome_q;
	logic [9:0]    res_slot_q;
	logic          due_q;

	entry_t        ent_mem [MAX_SLOTS];
	logic [1:0]    flg_mem [MAX_SLOTS];
	entry_t        ent_rd;
	logic [1:0]    flg_rd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;
	logic          ent_we, flg_we;
	logic [AW-1:0] mem_wa;
	entry_t        ent_wd;
	logic [1:0]    flg_wd;

	logic [NW-1:0] n_eff;
	logic          size_ok;
	logic          key_eq;
	logic [AW-1:0] hand_cur;
	logic [AW-1:0] hand_nxt;
	logic [CNT_W-1:0] req_nxt;
	logic          report_due_c;

	crbcd_hash u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   ({it_q.key_archive, it_q.key_handle, it_q.key_offset,
			it_q.key_packed_size, it_q.key_unpacked_size}),
		.done  (hash_done),
		.tag   (tag)
	);

	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[mem_wa] <= ent_wd;
		if (mem_re)
			ent_rd <= ent_mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (flg_we)
			flg_mem[mem_wa] <= flg_wd;
		if (mem_re)
			flg_rd <= flg_mem[mem_ra];
	end

	assign n_eff = (slot_count_q > 11'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : NW'(slot_count_q);
	assign size_ok = (in_item.key_unpacked_size != '0) &&
		({1'b0, in_item.key_unpacked_size} <= 33'(SLOT_BYTES));
	assign key_eq = (ent_rd.tag == tag) && (ent_rd.archive == it_q.key_archive) &&
		(ent_rd.handle == it_q.key_handle) && (ent_rd.offset == it_q.key_offset) &&
		(ent_rd.packed_size == it_q.key_packed_size) &&
		(ent_rd.unpacked_size == it_q.key_unpacked_size);
	assign hand_cur = ({1'b0, hand_q} >= n_q) ? '0 : hand_q;
	assign hand_nxt = ({1'b0, hand_cur} + NW'(1) < n_q) ? hand_cur + AW'(1) : '0;

	assign req_nxt = c_req_q + 32'd1;
	always_comb begin
		if (req_nxt <= REPORT_LIMIT)
			report_due_c = (req_nxt[9:0] == 10'd0);
		else
			report_due_c = (req_nxt[12:0] == 13'd0);
	end

	assign in_ready  = (st_q == ST_IDLE);
	assign cfg_ready = (st_q == ST_IDLE) && !in_valid;
	assign out_valid = (st_q == ST_OUT);
	assign out_item  = '{outcome: outcome_q, slot_index: res_slot_q,
		is_poisoned: poison_q, report_due: due_q, request_count: c_req_q,
		hit_count: c_hit_q, store_count: c_store_q, eviction_count: c_evict_q,
		verified_count: c_ver_q, mismatch_count: c_mis_q};
	assign hash_start = in_valid && in_ready;

	always_comb begin
		mem_re = 1'b0;
		mem_ra = scan_q[AW-1:0];
		ent_we = 1'b0;
		flg_we = 1'b0;
		mem_wa = slot_q;
		ent_wd = {tag, it_q.key_archive, it_q.key_handle, it_q.key_offset,
			it_q.key_packed_size, it_q.key_unpacked_size};
		flg_wd = 2'b11;
		unique case (st_q)
			ST_CLEAR: begin
				flg_we = 1'b1;
				mem_wa = clr_q;
				flg_wd = 2'b00;
			end
			ST_SCAN: begin
				mem_re = 1'b1;
				mem_ra = scan_q[AW-1:0];
			end
			ST_HIT: begin
				flg_we = 1'b1;
			end
			ST_VRD: begin
				mem_re = 1'b1;
				mem_ra = hand_cur;
			end
			ST_VCHK: begin
				flg_we = flg_rd[0] && flg_rd[1] && (steps_q != '0);
				mem_wa = slot_q;
				flg_wd = 2'b10;
			end
			ST_WR: begin
				ent_we = 1'b1;
				flg_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			slot_count_q <= '0;
			verify_q <= 1'b0;
			poison_q <= 1'b0;
			hand_q <= '0;
			c_req_q <= '0; c_hit_q <= '0; c_store_q <= '0;
			c_evict_q <= '0; c_ver_q <= '0; c_mis_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SLOT_COUNT:  slot_count_q <= cfg_data;
					REG_VERIFY_MODE: verify_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_SLOTS - 1))
						st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						it_q <= in_item;
						n_q <= n_eff;
						scan_q <= '0;
						outcome_q <= OUT_MISS;
						res_slot_q <= '0;
						due_q <= (in_item.action == ACT_REPORT) && report_due_c;
						if (in_item.action == ACT_REPORT) begin
							c_req_q <= req_nxt;
							st_q <= ST_OUT;
						end else if (((in_item.action == ACT_LOOKUP && !verify_q) ||
							in_item.action == ACT_STORE) && n_eff != '0 &&
							!poison_q && size_ok) begin
							st_q <= ST_HASH;
						end else begin
							st_q <= ST_OUT;
						end
					end
				end
				ST_HASH: begin
					if (hash_done)
						st_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_q == n_q) begin
						if (it_q.action == ACT_STORE) begin
							steps_q <= (NW+2)'({n_q, 1'b0}) + (NW+2)'(2);
							reused_q <= 1'b0;
							st_q <= ST_VRD;
						end else begin
							st_q <= ST_OUT;
						end
					end else begin
						addr_s1 <= scan_q[AW-1:0];
						st_q <= ST_SCHK;
					end
				end
				ST_SCHK: begin
					if (flg_rd[1] && key_eq) begin
						slot_q <= addr_s1;
						res_slot_q <= 10'(addr_s1);
						if (it_q.action == ACT_STORE && verify_q) begin
							if (it_q.data_match) begin
								c_ver_q <= c_ver_q + 32'd1;
								outcome_q <= OUT_VERIFIED;
								st_q <= ST_HIT;
							end else begin
								poison_q <= 1'b1;
								c_mis_q <= c_mis_q + 32'd1;
								outcome_q <= OUT_MISMATCH;
								st_q <= ST_OUT;
							end
						end else begin
							if (it_q.action == ACT_LOOKUP) begin
								c_hit_q <= c_hit_q + 32'd1;
								outcome_q <= OUT_HIT;
							end else begin
								outcome_q <= OUT_RESIDENT;
							end
							st_q <= ST_HIT;
						end
					end else begin
						scan_q <= scan_q + NW'(1);
						st_q <= ST_SCAN;
					end
				end
				ST_HIT: begin
					st_q <= ST_OUT;
				end
				ST_VRD: begin
					slot_q <= hand_cur;
					hand_q <= hand_nxt;
					st_q <= ST_VCHK;
				end
				ST_VCHK: begin
					if (steps_q == '0) begin
						reused_q <= 1'b1;
						st_q <= ST_WR;
					end else if (!flg_rd[1]) begin
						st_q <= ST_WR;
					end else if (flg_rd[0]) begin
						steps_q <= steps_q - (NW+2)'(1);
						st_q <= ST_VRD;
					end else begin
						reused_q <= 1'b1;
						st_q <= ST_WR;
					end
				end
				ST_WR: begin
					c_store_q <= c_store_q + 32'd1;
					if (reused_q)
						c_evict_q <= c_evict_q + 32'd1;
					outcome_q <= reused_q ? OUT_EVICT : OUT_FREE;
					res_slot_q <= 10'(slot_q);
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output both open");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_poison_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		poison_q |=> poison_q) else $error("poison cleared");
	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_VCHK |-> {1'b0, slot_q} < n_q) else $error("victim out of range");
`endif

endmodule

[verif/crbcd_checker.sv]
// ----------------------------------------------------------------------------
// crbcd_checker
// watches the item, result and config channels of the cache directory,
// predicts every result from a local copy of the slot state and compares
// ----------------------------------------------------------------------------
module crbcd_checker
	import crbcd_pkg::*;
#(
	parameter int MAX_SLOTS  = 1024,
	parameter int SLOT_BYTES = 262144
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_item,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_item,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  logic      cfg_index,
	input  logic [10:0] cfg_data,
	output int        errors,
	output int        pending,
	output int        results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	entry_t      dir_entry [MAX_SLOTS];
	logic        dir_used [MAX_SLOTS];
	logic        dir_ref [MAX_SLOTS];
	int unsigned hand;
	logic        poison;
	logic [31:0] n_req, n_hit, n_store, n_evict, n_ver, n_mis;
	logic [10:0] cur_slots;
	logic        cur_verify;
	out_item_t   expected_results [$];

	function automatic logic [31:0] block_tag(input in_item_t it);
		logic [31:0] h;
		logic [31:0] w [5];
		h = FNV_BASIS;
		w = '{it.key_archive, it.key_handle, it.key_offset, it.key_packed_size,
			it.key_unpacked_size};
		for (int i = 0; i < 5; i++)
			for (int b = 0; b < 4; b++)
				h = (h ^ {24'd0, w[i][8*b +: 8]}) * FNV_PRIME;
		return h;
	endfunction

	function automatic int unsigned advance_hand(input int unsigned n);
		int unsigned s;
		if (hand >= n)
			hand = 0;
		s = hand;
		hand = (hand + 1 < n) ? hand + 1 : 0;
		return s;
	endfunction

	function automatic out_item_t predict_directory(input in_item_t it);
		out_item_t   r;
		int unsigned n, s;
		int          f;
		logic [31:0] tg;
		logic        ok, reused, done;
		r = '0;
		n = (cur_slots > MAX_SLOTS) ? MAX_SLOTS : cur_slots;
		ok = n != 0 && !poison && it.key_unpacked_size != 0 &&
			it.key_unpacked_size <= SLOT_BYTES;
		tg = block_tag(it);
		f = -1;
		if (ok && (it.action == ACT_LOOKUP || it.action == ACT_STORE))
			for (int i = 0; i < n; i++)
				if (f < 0 && dir_used[i] && dir_entry[i] == {tg, it.key_archive,
						it.key_handle, it.key_offset, it.key_packed_size,
						it.key_unpacked_size})
					f = i;
		case (it.action)
			ACT_LOOKUP: begin
				if (ok && !cur_verify && f >= 0) begin
					dir_ref[f] = 1;
					n_hit++;
					r.outcome = OUT_HIT;
					r.slot_index = 10'(f);
				end
			end
			ACT_STORE: begin
				if (ok && f >= 0) begin
					r.slot_index = 10'(f);
					if (!cur_verify) begin
						dir_ref[f] = 1;
						r.outcome = OUT_RESIDENT;
					end else if (it.data_match) begin
						dir_ref[f] = 1;
						n_ver++;
						r.outcome = OUT_VERIFIED;
					end else begin
						poison = 1;
						n_mis++;
						r.outcome = OUT_MISMATCH;
					end
				end else if (ok) begin
					done = 0;
					reused = 0;
					s = 0;
					for (int k = 0; k < 2 * n + 2 && !done; k++) begin
						s = advance_hand(n);
						if (!dir_used[s])
							done = 1;
						else if (dir_ref[s])
							dir_ref[s] = 0;
						else begin
							reused = 1;
							done = 1;
						end
					end
					if (!done) begin
						s = advance_hand(n);
						reused = 1;
					end
					if (reused)
						n_evict++;
					dir_entry[s] = {tg, it.key_archive, it.key_handle, it.key_offset,
						it.key_packed_size, it.key_unpacked_size};
					dir_used[s] = 1;
					dir_ref[s] = 1;
					n_store++;
					r.outcome = reused ? OUT_EVICT : OUT_FREE;
					r.slot_index = 10'(s);
				end
			end
			ACT_REPORT: begin
				n_req++;
				if (n_req <= REPORT_LIMIT)
					r.report_due = (n_req % REPORT_EVERY) == 0;
				else
					r.report_due = (n_req % REPORT_LATE) == 0;
			end
			default: ;
		endcase
		r.is_poisoned = poison;
		r.request_count = n_req;
		r.hit_count = n_hit;
		r.store_count = n_store;
		r.eviction_count = n_evict;
		r.verified_count = n_ver;
		r.mismatch_count = n_mis;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				dir_used[i] = 0;
				dir_ref[i] = 0;
				dir_entry[i] = '0;
			end
			hand = 0;
			poison = 0;
			{n_req, n_hit, n_store, n_evict, n_ver, n_mis} = '0;
			cur_slots = 0;
			cur_verify = 0;
			expected_results.delete();
			errors = 0;
			pending = 0;
			results_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%t: result with none expected: %p", $time, out_item);
				end else begin
					e = expected_results.pop_front();
					if (out_item.outcome !== e.outcome ||
						out_item.slot_index !== e.slot_index ||
						out_item.is_poisoned !== e.is_poisoned ||
						out_item.report_due !== e.report_due ||
						out_item.request_count !== e.request_count ||
						out_item.hit_count !== e.hit_count ||
						out_item.store_count !== e.store_count ||
						out_item.eviction_count !== e.eviction_count ||
						out_item.verified_count !== e.verified_count ||
						out_item.mismatch_count !== e.mismatch_count) begin
						errors++;
						$display("%t: mismatch expected %p actual %p", $time, e, out_item);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SLOT_COUNT)
					cur_slots = cfg_data;
				else
					cur_verify = cfg_data[0];
			end
			if (in_valid && in_ready)
				expected_results.push_back(predict_directory(in_item));
			pending = expected_results.size();
		end
	end

	final begin
		if (expected_results.size() != 0)
			$display("%0d results never arrived", expected_results.size());
	end
endmodule

[verif/clock_replacement_block_cache_directory_test.sv]
// ----------------------------------------------------------------------------
// clock_replacement_block_cache_directory_test
// drives lookups, stores and reports through several slot counts and both
// modes, with random gaps on both sides; a checker predicts and compares
// ----------------------------------------------------------------------------
module clock_replacement_block_cache_directory_test;
	import crbcd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 200000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_ready = 0;
	out_item_t   out_item;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_index = 0;
	logic [10:0] cfg_data = 0;
	int          errors, pending, results_seen;
	int          idle_cycles = 0;
	int          items_sent = 0;
	bit          rx_hold = 0;
	in_item_t    key_pool [16];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	clock_replacement_block_cache_directory u_dut (
		.clk, .arst_n, .in_valid, .in_ready, .in_item, .out_valid, .out_ready,
		.out_item, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	crbcd_checker u_checker (
		.clk, .arst_n, .in_valid, .in_ready, .in_item, .out_valid, .out_ready,
		.out_item, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.errors, .pending, .results_seen
	);

	function automatic int gap_length();
		if ($urandom_range(9) < 4)
			return 0;
		if ($urandom_range(19) == 0)
			return $urandom_range(60, 20);
		return $urandom_range(3, 1);
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (!rx_hold)
			out_ready <= 1;
		else
			out_ready <= $urandom_range(9) < 6 ? 1'b0 : 1'b1;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("watchdog expired");
			$display("** clock_replacement_block_cache_directory: FAILED **");
			$finish;
		end
	end

	// valid stays high after an accept until the next call replaces or drops it
	task automatic send_item(input in_item_t it);
		int g;
		g = gap_length();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (7 * 1024 + 60) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [10:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic in_item_t random_key();
		in_item_t it;
		it.action = ACT_STORE;
		it.key_archive = $urandom;
		it.key_handle = $urandom;
		it.key_offset = $urandom;
		it.key_packed_size = $urandom;
		it.key_unpacked_size = $urandom_range(262144, 1);
		it.data_match = 1'b0;
		return it;
	endfunction

	function automatic in_item_t pick_item(input int pool_n);
		in_item_t it;
		int r;
		r = $urandom_range(99);
		if (r < 85) begin
			it = key_pool[$urandom_range(pool_n - 1)];
			it.action = $urandom_range(1) ? ACT_LOOKUP : ACT_STORE;
		end else if (r < 92) begin
			it = random_key();
			it.action = ACT_REPORT;
		end else begin
			it.action = 2'($urandom_range(3));
			it.key_archive = $urandom;
			it.key_handle = $urandom;
			it.key_offset = $urandom;
			it.key_packed_size = $urandom;
			it.key_unpacked_size = $urandom;
		end
		it.data_match = $urandom_range(9) != 0;
		return it;
	endfunction

	task automatic random_phase(input int count, input int pool_n);
		for (int i = 0; i < pool_n; i++)
			key_pool[i] = random_key();
		for (int i = 0; i < count; i++)
			send_item(pick_item(pool_n));
	endtask

	initial begin
		in_item_t it;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		// directed part: cache off, then tiny cache
		it = random_key();
		send_item(it);
		it.action = ACT_REPORT;
		send_item(it);
		it.action = ACT_UNUSED;
		send_item(it);
		drain();
		write_reg(REG_SLOT_COUNT, 11'd2);
		write_reg(REG_VERIFY_MODE, 11'd0);
		it = random_key();
		it.key_archive = '1; it.key_handle = '0; it.key_offset = '1;
		it.key_packed_size = '0; it.key_unpacked_size = 32'd262144;
		send_item(it);
		send_item(it);
		it.action = ACT_LOOKUP;
		send_item(it);
		it.key_unpacked_size = 32'd1;
		send_item(it);
		it.action = ACT_STORE;
		send_item(it);
		send_item(random_key());
		send_item(random_key());
		it.key_unpacked_size = 32'd0;
		send_item(it);
		it.key_unpacked_size = 32'd262145;
		send_item(it);
		it.key_unpacked_size = '1;
		send_item(it);
		it.action = ACT_REPORT;
		send_item(it);
		drain();
		write_reg(REG_SLOT_COUNT, 11'h7FF);
		rx_hold = 1;
		random_phase(50, 16);
		drain();
		write_reg(REG_SLOT_COUNT, 11'd3);
		random_phase(60, 8);
		drain();
		write_reg(REG_SLOT_COUNT, 11'd1);
		random_phase(30, 4);
		drain();
		write_reg(REG_SLOT_COUNT, 11'd8);
		random_phase(50, 12);
		drain();
		write_reg(REG_SLOT_COUNT, 11'd1024);
		rx_hold = 0;
		random_phase(30, 10);
		drain();
		rx_hold = 1;
		write_reg(REG_SLOT_COUNT, 11'd6);
		write_reg(REG_VERIFY_MODE, 11'd1);
		random_phase(60, 6);
		drain();
		if (pending != 0)
			$display("items still outstanding at end");
		$display("sent %0d items, checked %0d results over slot counts 0 to 2047",
			items_sent, results_seen);
		$display("both modes exercised, poisoning reachable in verify mode");
		if (errors == 0 && pending == 0)
			$display("** clock_replacement_block_cache_directory: PASSED **");
		else
			$display("** clock_replacement_block_cache_directory: FAILED **");
		$finish;
	end
endmodule
